/* rtl/core/ptf_pkg.sv */
// shared types, codes and float helpers for the pixel to texel format converter
package ptf_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int CHAN_W       = 32;
    localparam int LANE_IDX_W   = $clog2(MAX_CHANNELS);
    localparam int CFG_W        = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_STAGES   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TYPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANNELS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_KIND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BYTES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_CHANNELS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_RED_BLUE = 3'd5;

    localparam logic [2:0] SRC_FLOAT  = 3'd0;
    localparam logic [2:0] SRC_UBYTE  = 3'd1;
    localparam logic [2:0] SRC_SBYTE  = 3'd2;
    localparam logic [2:0] SRC_USHORT = 3'd3;
    localparam logic [2:0] SRC_SHORT  = 3'd4;
    localparam logic [2:0] SRC_UINT   = 3'd5;
    localparam logic [2:0] SRC_INT    = 3'd6;
    localparam logic [2:0] SRC_BOOL   = 3'd7;

    localparam logic [2:0] KIND_UNORM  = 3'd0;
    localparam logic [2:0] KIND_SNORM  = 3'd1;
    localparam logic [2:0] KIND_UINT   = 3'd2;
    localparam logic [2:0] KIND_SINT   = 3'd3;
    localparam logic [2:0] KIND_SFLOAT = 3'd4;

    localparam logic [31:0] F32_ONE = 32'h3F80_0000;

    typedef struct packed {
        logic [2:0] source_type;
        logic [2:0] kind;
        logic [2:0] bytes;
        logic [2:0] sc;
        logic [2:0] ic;
        logic [2:0] n;
        logic       exact;
        logic       swap;
    } cfg_t;

    typedef logic [MAX_CHANNELS-1:0][CHAN_W-1:0] chan_vec_t;

    // leading zero count, 32 for zero
    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] lz;
        lz = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                lz = 6'(31 - i);
            end
        end
        return lz;
    endfunction

    // pack with round increment, carry bumps the exponent
    function automatic logic [31:0] f32_pack(input logic s, input logic [7:0] ex,
                                             input logic [23:0] mant, input logic inc);
        logic [24:0] m25;
        m25 = {1'b0, mant} + 25'(inc);
        if (m25[24])
        begin
            return {s, 8'(ex + 8'd1), 23'd0};
        end
        return {s, ex, m25[22:0]};
    endfunction

    // round half away from zero, low 32 bits of the integer
    function automatic logic [31:0] round_low32(input logic [31:0] v);
        logic [7:0]  ex;
        logic [23:0] m;
        logic [4:0]  r;
        logic [31:0] mag;
        logic        rb;
        ex  = v[30:23];
        m   = {1'b1, v[22:0]};
        mag = '0;
        rb  = 1'b0;
        r   = '0;
        if (ex == 8'hFF || ex >= 8'd182 || ex < 8'd126)
        begin
            return '0;
        end
        if (ex <= 8'd150)
        begin
            r   = 5'(8'd150 - ex);
            mag = 32'(m >> r);
            if (r != 5'd0)
            begin
                rb = m[5'(r - 5'd1)];
            end
            mag = mag + 32'(rb);
        end
        else
        begin
            mag = 32'(56'(m) << 5'(ex - 8'd150));
        end
        return v[31] ? (~mag + 32'd1) : mag;
    endfunction

    // float32 to half, round to nearest even
    function automatic logic [15:0] f32_to_half(input logic [31:0] b);
        logic              s;
        logic [7:0]        ex;
        logic [22:0]       mn;
        logic signed [9:0] e;
        logic [23:0]       m;
        logic [4:0]        sh;
        logic [23:0]       h;
        logic [23:0]       rem;
        logic [23:0]       hw;
        s  = b[31];
        ex = b[30:23];
        mn = b[22:0];
        e  = signed'({2'b00, ex}) - 10'sd112;
        m  = {1'b1, mn};
        sh = '0;
        if (ex == 8'hFF)
        begin
            return {s, (mn != 23'd0) ? 15'h7E00 : 15'h7C00};
        end
        if (e >= 10'sd31)
        begin
            return {s, 15'h7C00};
        end
        if (e <= 10'sd0)
        begin
            if (e < -10'sd10)
            begin
                return {s, 15'd0};
            end
            sh  = 5'(10'sd14 - e);
            h   = m >> sh;
            rem = m & ((24'd1 << sh) - 24'd1);
            hw  = 24'd1 << 5'(sh - 5'd1);
        end
        else
        begin
            h   = 24'({e[4:0], mn[22:13]});
            rem = 24'(mn[12:0]);
            hw  = 24'h001000;
        end
        if (rem > hw || (rem == hw && h[0]))
        begin
            h = h + 24'd1;
        end
        return {s, h[14:0]};
    endfunction

endpackage

/* rtl/core/ptf_lane.sv */
// one channel lane: decode to float32, clamp, scale, round and encode
module ptf_lane (
    input  logic                                clk,
    input  logic [ptf_pkg::NUM_STAGES-1:0]      en,
    input  ptf_pkg::cfg_t                       cfg,
    input  logic [ptf_pkg::LANE_IDX_W-1:0]      lane_idx,
    input  logic [ptf_pkg::CHAN_W-1:0]          raw,
    output logic [ptf_pkg::CHAN_W-1:0]          result
);

    // stage 1
    logic        sgn1_reg, sgn1_next;
    logic [31:0] mag1_reg, mag1_next;
    logic [5:0]  lz1_reg;
    logic [31:0] raw1_reg;
    logic        present1_reg;
    // stage 2
    logic [31:0] f2_reg, f2_next;
    logic [31:0] raw2_reg;
    // stage 3
    logic [39:0] prod3_reg, prod3_next;
    logic [31:0] c3_reg, c3_next;
    logic        nan3_reg, nan3_next;
    logic [31:0] raw3_reg;
    // stage 4
    logic [31:0] f4_reg, f4_next;
    logic [15:0] h4_reg;
    logic [31:0] raw4_reg;
    // stage 5
    logic [31:0] res5_reg, res5_next;

    logic [23:0] mant2;
    logic [7:0]  exp2;
    logic        inc2;
    logic [31:0] shi2;
    logic [39:0] s8;
    logic [34:0] s7;
    logic [2:0]  z2;
    logic [15:0] k3;
    logic [4:0]  kb3, kb4;
    logic [39:0] top4;
    logic [23:0] mant4;
    logic [7:0]  exp4;
    logic        inc4;
    logic        norm4;

    always_comb
    begin
        sgn1_next = 1'b0;
        mag1_next = '0;
        unique case (cfg.source_type)
            ptf_pkg::SRC_SBYTE:
            begin
                sgn1_next = raw[7];
                mag1_next = 32'(raw[7] ? 8'(~raw[7:0] + 8'd1) : raw[7:0]);
            end
            ptf_pkg::SRC_USHORT: mag1_next = 32'(raw[15:0]);
            ptf_pkg::SRC_SHORT:
            begin
                sgn1_next = raw[15];
                mag1_next = 32'(raw[15] ? 16'(~raw[15:0] + 16'd1) : raw[15:0]);
            end
            ptf_pkg::SRC_UINT: mag1_next = raw;
            ptf_pkg::SRC_INT:
            begin
                sgn1_next = raw[31];
                mag1_next = raw[31] ? (~raw + 32'd1) : raw;
            end
            ptf_pkg::SRC_FLOAT, ptf_pkg::SRC_UBYTE, ptf_pkg::SRC_BOOL:
                mag1_next = 32'(raw[7:0]);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sgn1_reg     <= sgn1_next;
            mag1_reg     <= mag1_next;
            lz1_reg      <= ptf_pkg::lzc32(mag1_next);
            raw1_reg     <= raw;
            present1_reg <= {1'b0, lane_idx} < cfg.n;
        end
    end

    // stage 2: build float32
    always_comb
    begin
        shi2  = mag1_reg << lz1_reg[4:0];
        s8    = {5{mag1_reg[7:0]}};
        s7    = {5{mag1_reg[6:0]}};
        z2    = '0;
        mant2 = '0;
        exp2  = '0;
        inc2  = 1'b0;
        f2_next = '0;
        unique case (cfg.source_type)
            ptf_pkg::SRC_FLOAT: f2_next = raw1_reg;
            ptf_pkg::SRC_SBYTE:
            begin
                z2 = 3'(lz1_reg - 6'd25);
                s7 = s7 << z2;
                mant2 = s7[34:11];
                inc2  = s7[10];
                exp2  = 8'd126 - 8'(z2);
                if (mag1_reg[7])
                begin
                    f2_next = {1'b1, ptf_pkg::F32_ONE[30:0]};
                end
                else if (mag1_reg[6:0] == 7'd0)
                begin
                    f2_next = '0;
                end
                else if (mag1_reg[6:0] == 7'h7F)
                begin
                    f2_next = {sgn1_reg, ptf_pkg::F32_ONE[30:0]};
                end
                else
                begin
                    f2_next = ptf_pkg::f32_pack(sgn1_reg, exp2, mant2, inc2);
                end
            end
            ptf_pkg::SRC_USHORT, ptf_pkg::SRC_SHORT, ptf_pkg::SRC_UINT, ptf_pkg::SRC_INT:
            begin
                mant2 = shi2[31:8];
                inc2  = shi2[7] && ((|shi2[6:0]) || shi2[8]);
                exp2  = 8'(8'd158 - 8'(lz1_reg));
                if (mag1_reg == 32'd0)
                begin
                    f2_next = '0;
                end
                else
                begin
                    f2_next = ptf_pkg::f32_pack(sgn1_reg, exp2, mant2, inc2);
                end
            end
            ptf_pkg::SRC_UBYTE, ptf_pkg::SRC_BOOL:
            begin
                z2 = lz1_reg[2:0];
                s8 = s8 << z2;
                mant2 = s8[39:16];
                inc2  = s8[15];
                exp2  = 8'd126 - 8'(z2);
                if (mag1_reg[7:0] == 8'd0)
                begin
                    f2_next = '0;
                end
                else if (mag1_reg[7:0] == 8'hFF)
                begin
                    f2_next = ptf_pkg::F32_ONE;
                end
                else
                begin
                    f2_next = ptf_pkg::f32_pack(1'b0, exp2, mant2, inc2);
                end
            end
        endcase
        if (!present1_reg)
        begin
            f2_next = ptf_pkg::F32_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            f2_reg   <= f2_next;
            raw2_reg <= raw1_reg;
        end
    end

    // stage 3: clamp and scale
    always_comb
    begin
        nan3_next = (f2_reg[30:23] == 8'hFF) && (f2_reg[22:0] != 23'd0);
        c3_next   = f2_reg;
        k3        = 16'd255;
        unique case (cfg.kind)
            ptf_pkg::KIND_UNORM:
            begin
                k3 = (cfg.bytes == 3'd1) ? 16'd255 : 16'd65535;
                if (f2_reg[31] && f2_reg[30:0] != 31'd0)
                begin
                    c3_next = '0;
                end
                else if (f2_reg[30:0] > ptf_pkg::F32_ONE[30:0])
                begin
                    c3_next = ptf_pkg::F32_ONE;
                end
            end
            ptf_pkg::KIND_SNORM:
            begin
                k3 = (cfg.bytes == 3'd1) ? 16'd127 : 16'd32767;
                if (f2_reg[30:0] > ptf_pkg::F32_ONE[30:0])
                begin
                    c3_next = {f2_reg[31], ptf_pkg::F32_ONE[30:0]};
                end
            end
            ptf_pkg::KIND_UINT:
            begin
                if (f2_reg[31] && !nan3_next)
                begin
                    c3_next = '0;
                end
            end
            default: c3_next = f2_reg;
        endcase
        prod3_next = {16'd0, 1'b1, c3_next[22:0]} * {24'd0, k3};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            prod3_reg <= prod3_next;
            c3_reg    <= c3_next;
            nan3_reg  <= nan3_next;
            raw3_reg  <= raw2_reg;
        end
    end

    // stage 4: normalize the product, half conversion
    always_comb
    begin
        if (cfg.kind == ptf_pkg::KIND_UNORM)
        begin
            kb4 = (cfg.bytes == 3'd1) ? 5'd8 : 5'd16;
        end
        else
        begin
            kb4 = (cfg.bytes == 3'd1) ? 5'd7 : 5'd15;
        end
        kb3  = 5'd16 - kb4;
        top4 = prod3_reg << kb3;
        if (top4[39])
        begin
            mant4 = top4[39:16];
            inc4  = top4[15] && ((|top4[14:0]) || top4[16]);
            exp4  = c3_reg[30:23] + 8'(kb4);
        end
        else
        begin
            mant4 = top4[38:15];
            inc4  = top4[14] && ((|top4[13:0]) || top4[15]);
            exp4  = c3_reg[30:23] + 8'(kb4) - 8'd1;
        end
        norm4 = (cfg.kind == ptf_pkg::KIND_UNORM) || (cfg.kind == ptf_pkg::KIND_SNORM);
        if (!norm4)
        begin
            f4_next = c3_reg;
        end
        else if (nan3_reg || c3_reg[30:23] == 8'd0)
        begin
            f4_next = '0;
        end
        else
        begin
            f4_next = ptf_pkg::f32_pack(c3_reg[31], exp4, mant4, inc4);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            f4_reg   <= f4_next;
            h4_reg   <= ptf_pkg::f32_to_half(c3_reg);
            raw4_reg <= raw3_reg;
        end
    end

    // stage 5: integer rounding, half or float select, channel width and raw passthrough when exact
    always_comb
    begin
        unique case (cfg.kind)
            ptf_pkg::KIND_UNORM, ptf_pkg::KIND_SNORM:
            begin
                res5_next = ptf_pkg::round_low32(f4_reg);
                res5_next = (cfg.bytes == 3'd1) ? (res5_next & 32'hFF)
                                                : (res5_next & 32'hFFFF);
            end
            ptf_pkg::KIND_UINT, ptf_pkg::KIND_SINT:
            begin
                res5_next = ptf_pkg::round_low32(f4_reg);
                if (cfg.bytes == 3'd1)
                begin
                    res5_next = res5_next & 32'hFF;
                end
                else if (cfg.bytes == 3'd2)
                begin
                    res5_next = res5_next & 32'hFFFF;
                end
            end
            ptf_pkg::KIND_SFLOAT:
                res5_next = (cfg.bytes == 3'd2) ? {16'd0, h4_reg} : f4_reg;
            default: res5_next = '0;
        endcase
        if (cfg.exact && ({1'b0, lane_idx} < cfg.sc))
        begin
            if (cfg.bytes == 3'd1)
            begin
                res5_next = raw4_reg & 32'hFF;
            end
            else if (cfg.bytes == 3'd2)
            begin
                res5_next = raw4_reg & 32'hFFFF;
            end
            else
            begin
                res5_next = raw4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            res5_reg <= res5_next;
        end
    end

    assign result = res5_reg;

endmodule

/* rtl/core/ptf_merge.sv */
// channel routing, red/blue swap, unused channel clearing and output register
module ptf_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ptf_pkg::chan_vec_t                 lane_res,
    input  logic                               in_last,
    input  ptf_pkg::cfg_t                      cfg,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ptf_pkg::MAX_CHANNELS*ptf_pkg::CHAN_W-1:0] m_tdata,
    output logic                               m_tlast
);

    logic               valid_reg, valid_next;
    ptf_pkg::chan_vec_t texel_reg, texel_next;
    logic               last_reg;

    assign in_ready = !valid_reg || m_tready;

    always_comb
    begin
        logic [ptf_pkg::LANE_IDX_W-1:0] sel;
        sel = '0;
        for (int i = 0; i < ptf_pkg::MAX_CHANNELS; i++)
        begin
            sel = (cfg.swap && i < 3) ? ptf_pkg::LANE_IDX_W'(2 - i)
                                      : ptf_pkg::LANE_IDX_W'(i);
            texel_next[i] = (3'(i) < cfg.ic) ? lane_res[sel] : '0;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            texel_reg <= texel_next;
            last_reg  <= in_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = texel_reg;
    assign m_tlast  = last_reg;

endmodule

/* rtl/core/pixel_to_texel_format_convert_core.sv */
// top level: config registers, lane pipeline control and merge
// an accepted input beat passes the five lane stage registers and then the merge output register
// throughput: one pixel per cycle unless the output stalls, set by the five lane stages and the output register
// ready is combinational through all stages, so a full pipeline stalls the input in the same
// cycle while empty stages keep filling and bubbles are squeezed out
// reset: asynchronous active low, clears all valid flags and loads register defaults
module pixel_to_texel_format_convert_core (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             s_tvalid,
    output logic                                             s_tready,
    // src_chan0, src_chan1, src_chan2, src_chan3
    input  logic [ptf_pkg::MAX_CHANNELS*ptf_pkg::CHAN_W-1:0] s_tdata,
    input  logic                                             s_tlast,
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    // texel_chan0, texel_chan1, texel_chan2, texel_chan3
    output logic [ptf_pkg::MAX_CHANNELS*ptf_pkg::CHAN_W-1:0] m_tdata,
    output logic                                             m_tlast,
    input  logic                                             cfg_we,
    input  logic [ptf_pkg::CFG_IDX_W-1:0]                    cfg_index,
    input  logic [ptf_pkg::CFG_W-1:0]                        cfg_wdata
);

    logic [2:0] source_type_reg;
    logic [2:0] src_count_reg;
    logic [2:0] kind_reg;
    logic [2:0] bytes_reg;
    logic [2:0] img_count_reg;
    logic       swap_reg;

    logic [ptf_pkg::NUM_STAGES-1:0] v_reg, v_next;
    logic [ptf_pkg::NUM_STAGES-1:0] last_reg;
    logic [ptf_pkg::NUM_STAGES:0]   rdy;
    logic                           merge_ready;
    ptf_pkg::cfg_t                  cfg;
    ptf_pkg::chan_vec_t             s_chan;
    ptf_pkg::chan_vec_t             lane_res;
    logic                           match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_type_reg <= ptf_pkg::SRC_UBYTE;
            src_count_reg   <= 3'd4;
            kind_reg        <= ptf_pkg::KIND_UNORM;
            bytes_reg       <= 3'd1;
            img_count_reg   <= 3'd4;
            swap_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ptf_pkg::REG_SOURCE_TYPE:   source_type_reg <= cfg_wdata;
                ptf_pkg::REG_SRC_CHANNELS:  src_count_reg   <= cfg_wdata;
                ptf_pkg::REG_IMAGE_KIND:    kind_reg        <= cfg_wdata;
                ptf_pkg::REG_IMAGE_BYTES:   bytes_reg       <= cfg_wdata;
                ptf_pkg::REG_IMG_CHANNELS:  img_count_reg   <= cfg_wdata;
                ptf_pkg::REG_SWAP_RED_BLUE: swap_reg        <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // derived configuration
    always_comb
    begin
        cfg.source_type = source_type_reg;
        cfg.kind        = kind_reg;
        cfg.bytes       = bytes_reg;
        cfg.sc = (src_count_reg == 3'd0) ? 3'd1
               : ((src_count_reg > 3'(ptf_pkg::MAX_CHANNELS))
                  ? 3'(ptf_pkg::MAX_CHANNELS) : src_count_reg);
        cfg.ic = (img_count_reg == 3'd0) ? 3'd1
               : ((img_count_reg > 3'(ptf_pkg::MAX_CHANNELS))
                  ? 3'(ptf_pkg::MAX_CHANNELS) : img_count_reg);
        cfg.n  = (cfg.sc < cfg.ic) ? cfg.sc : cfg.ic;
        unique case (source_type_reg)
            ptf_pkg::SRC_FLOAT:  match = kind_reg == ptf_pkg::KIND_SFLOAT && bytes_reg == 3'd4;
            ptf_pkg::SRC_UBYTE:  match = kind_reg == ptf_pkg::KIND_UNORM && bytes_reg == 3'd1;
            ptf_pkg::SRC_SBYTE:  match = kind_reg == ptf_pkg::KIND_SNORM && bytes_reg == 3'd1;
            ptf_pkg::SRC_USHORT: match = kind_reg == ptf_pkg::KIND_UINT && bytes_reg == 3'd2;
            ptf_pkg::SRC_SHORT:  match = kind_reg == ptf_pkg::KIND_SINT && bytes_reg == 3'd2;
            ptf_pkg::SRC_UINT:   match = kind_reg == ptf_pkg::KIND_UINT && bytes_reg == 3'd4;
            ptf_pkg::SRC_INT:    match = kind_reg == ptf_pkg::KIND_SINT && bytes_reg == 3'd4;
            default:             match = 1'b0;
        endcase
        cfg.exact = match && !swap_reg && (cfg.ic >= cfg.sc);
        cfg.swap  = swap_reg && (cfg.ic >= 3'd3);
    end

    // stage handshake chain
    always_comb
    begin
        rdy[ptf_pkg::NUM_STAGES] = merge_ready;
        for (int i = ptf_pkg::NUM_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_next[0] = rdy[0] ? s_tvalid : v_reg[0];
        for (int i = 1; i < ptf_pkg::NUM_STAGES; i++)
        begin
            v_next[i] = rdy[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            last_reg[0] <= s_tlast;
        end
        for (int i = 1; i < ptf_pkg::NUM_STAGES; i++)
        begin
            if (rdy[i])
            begin
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    assign s_chan = s_tdata;

    for (genvar g = 0; g < ptf_pkg::MAX_CHANNELS; g++)
    begin : g_lane
        ptf_lane u_lane (
            .clk      (clk),
            .en       (rdy[ptf_pkg::NUM_STAGES-1:0]),
            .cfg      (cfg),
            .lane_idx (ptf_pkg::LANE_IDX_W'(g)),
            .raw      (s_chan[g]),
            .result   (lane_res[g])
        );
    end

    ptf_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v_reg[ptf_pkg::NUM_STAGES-1]),
        .in_ready (merge_ready),
        .lane_res (lane_res),
        .in_last  (last_reg[ptf_pkg::NUM_STAGES-1]),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // empty pipeline always takes a beat
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg == '0 && !m_tvalid) |-> s_tready)
        else $error("empty pipeline not ready");

    // a beat into an empty pipeline reaches the output through the five lane stages and the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && v_reg == '0 && !m_tvalid) |-> ##6 m_tvalid)
        else $error("beat lost or late in pipeline");

    // last lane stage holds while the output is stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ptf_pkg::NUM_STAGES-1] && m_tvalid && !m_tready)
        |=> v_reg[ptf_pkg::NUM_STAGES-1])
        else $error("stage dropped under back pressure");

    // full pipeline with stalled output refuses input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg == '1 && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken into full pipeline");

endmodule
